// File: sv/acs_pkg.sv
// Shared types and constants of the ant colony next-city select engine.
`timescale 1ns / 1ps
`default_nettype none
package acs_pkg;

   localparam int MAX_CITIES  = 64;
   localparam int CITY_W      = 6;
   localparam int COORD_W     = 12;
   localparam int XY_W        = 2 * COORD_W;
   localparam int PHER_W      = 32;
   localparam int PH_AW       = 12;
   localparam int PH_DEPTH    = 4096;
   localparam int LEN_W       = 24;
   localparam int FRAC_W      = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int COUNT_W     = 7;
   localparam int DIST_W      = 17;
   localparam int SQ_W        = 24;
   localparam int RAD_W       = 34;
   localparam int SREM_W      = 18;
   localparam int SQRT_STEPS  = 17;
   localparam int WT_W        = 48;
   localparam int SUM_W       = 56;
   localparam int QUO_W       = 70;
   localparam int DVS_W       = 24;
   localparam int DIV_STEPS   = 70;
   localparam int AMT_W       = 36;
   localparam int MUL_AW      = 56;
   localparam int MUL_BW      = 16;
   localparam int MUL_W       = 72;
   localparam int STEP_W      = 7;
   localparam int WRAM_W      = DIST_W + WT_W;

   localparam logic [PHER_W-1:0] PHER_ONE  = 32'd65536;
   localparam logic [PHER_W-1:0] PHER_MAX  = 32'hFFFF_FFFF;
   localparam logic [FRAC_W-1:0] FRAC_DIV  = 16'd65535;

   typedef enum logic [2:0] {
      MODE_LOAD    = 3'd0,
      MODE_WRITE   = 3'd1,
      MODE_EVAP    = 3'd2,
      MODE_DEPOSIT = 3'd3,
      MODE_START   = 3'd4,
      MODE_SELECT  = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EVAP_FACTOR = 2'd0,
      CSR_DEPOSIT_QTY = 2'd1,
      CSR_CITY_COUNT  = 2'd2
   } csr_index_type;

   typedef enum logic [22:0] {
      ST_CLEAR    = 23'h000001,
      ST_IDLE     = 23'h000002,
      ST_EVAP_RD  = 23'h000004,
      ST_EVAP_MUL = 23'h000008,
      ST_EVAP_WR  = 23'h000010,
      ST_DEP_DIV  = 23'h000020,
      ST_DEP_RD   = 23'h000040,
      ST_DEP_WR   = 23'h000080,
      ST_SEL_CUR  = 23'h000100,
      ST_SEL_CURW = 23'h000200,
      ST_P1_RD    = 23'h000400,
      ST_P1_CHK   = 23'h000800,
      ST_P1_MULX  = 23'h001000,
      ST_P1_MULY  = 23'h002000,
      ST_P1_SUM   = 23'h004000,
      ST_P1_SQRT  = 23'h008000,
      ST_P1_DIV   = 23'h010000,
      ST_THR_MUL  = 23'h020000,
      ST_THR_LD   = 23'h040000,
      ST_THR_DIV  = 23'h080000,
      ST_P2_RD    = 23'h100000,
      ST_P2_CHK   = 23'h200000,
      ST_OUT      = 23'h400000
   } state_type;

   typedef struct packed {
      logic [CITY_W-1:0] city;
      logic [DIST_W-1:0] distance;
      logic              none;
   } result_type;

endpackage
`default_nettype wire

// File: sv/acs_req_if.sv
// Request channel interface of the ant colony engine.
`timescale 1ns / 1ps
`default_nettype none
interface acs_req_if;
   import acs_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          mode;
   logic [CITY_W-1:0]   first_index;
   logic [CITY_W-1:0]   second_index;
   logic [COORD_W-1:0]  coord_x;
   logic [COORD_W-1:0]  coord_y;
   logic [PHER_W-1:0]   pheromone_word;
   logic [LEN_W-1:0]    tour_length;
   logic [FRAC_W-1:0]   random_fraction;
   modport source(output valid, mode, first_index, second_index, coord_x, coord_y,
                  pheromone_word, tour_length, random_fraction, input ready);
   modport sink(input valid, mode, first_index, second_index, coord_x, coord_y,
                pheromone_word, tour_length, random_fraction, output ready);
endinterface
`default_nettype wire

// File: sv/acs_rsp_if.sv
// Response channel interface of the ant colony engine.
`timescale 1ns / 1ps
`default_nettype none
interface acs_rsp_if;
   import acs_pkg::*;
   logic               valid;
   logic               ready;
   logic [CITY_W-1:0]  chosen_city;
   logic [DIST_W-1:0]  step_distance;
   logic               none_left;
   modport source(output valid, chosen_city, step_distance, none_left, input ready);
   modport sink(input valid, chosen_city, step_distance, none_left, output ready);
endinterface
`default_nettype wire

// File: sv/ant_colony_next_city_select.sv
// Top level of the ant colony next-city select engine.
// Load city, write pheromone and start tour are done on the request transfer itself.
// Evaporate walks every pheromone matrix entry through read, multiply and write states.
// Deposit, for a nonzero tour length, runs 70 divider steps, then two read-modify-writes.
// Select weighs each unvisited city at a distinct place (17 root steps, 70 divider steps),
// gives skipped cities zero weight, folds the threshold and then walks the cities to pick one.
// Synchronous reset clears control state, sets register defaults, then sweeps the pheromone RAM to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module ant_colony_next_city_select (
   input  wire logic                          clock,
   input  wire logic                          reset,
   acs_req_if.sink                            req_chan,
   acs_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [acs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [acs_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import acs_pkg::*;

   // Control state
   state_type               state_ff, state_in;
   logic [PH_AW-1:0]        cnt_ff, cnt_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    dep_pass_ff, dep_pass_in;
   logic [MAX_CITIES-1:0]   visited_ff, visited_in;
   logic [CITY_W-1:0]       cur_ff, cur_in;
   logic [CSR_DATA_W-1:0]   evap_factor_ff, evap_factor_in;
   logic [CSR_DATA_W-1:0]   deposit_qty_ff, deposit_qty_in;
   logic [COUNT_W-1:0]      city_count_ff, city_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [CITY_W-1:0]       a_ff, a_in, b_ff, b_in;
   logic [FRAC_W-1:0]       rnd_ff, rnd_in;
   logic [XY_W-1:0]         cur_xy_ff, cur_xy_in;
   logic [COORD_W-1:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic [PHER_W-1:0]       tau_ff, tau_in;
   logic [MUL_W-1:0]        mul_ff;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [DIST_W-1:0]       root_ff, root_in;
   logic [SREM_W-1:0]       srem_ff, srem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [DVS_W-1:0]        drem_ff, drem_in;
   logic [DVS_W-1:0]        dvs_ff, dvs_in;
   logic [AMT_W-1:0]        amt_ff, amt_in;
   logic [SUM_W-1:0]        total_ff, total_in, cum_ff, cum_in, thr_ff, thr_in;
   result_type              res_ff, res_in, rsp_data_ff, rsp_data_in;

   // Shared multiplier
   logic [MUL_AW-1:0]       mul_a;
   logic [MUL_BW-1:0]       mul_b;
   logic [MUL_W-1:0]        mul_prod;

   // Shared restoring divider, one quotient bit a cycle
   logic [DVS_W:0]          div_rsh, div_sub;
   logic                    div_ge;
   logic [DVS_W-1:0]        div_rem_next;
   logic [QUO_W-1:0]        div_quo_next;

   // Threshold fold by 65535: v = h*65536 + l = h*65535 + (h + l)
   logic [SUM_W-1:0]        fold_hi;
   logic [QUO_W-1:0]        fold_sum;

   // Root unit, one result bit a cycle
   logic [SREM_W+1:0]       sq_rt, sq_trial, sq_diff;
   logic                    sq_ge;
   logic [SREM_W-1:0]       sq_rem_next;
   logic [DIST_W-1:0]       sq_root_next;

   // RAM ports
   logic                    ph_we;
   logic [PH_AW-1:0]        ph_waddr, ph_raddr;
   logic [PHER_W-1:0]       ph_wdata, ph_rdata;
   logic                    co_we;
   logic [CITY_W-1:0]       co_waddr, co_raddr;
   logic [XY_W-1:0]         co_wdata, co_rdata;
   logic                    wt_we;
   logic [CITY_W-1:0]       wt_waddr, wt_raddr;
   logic [WRAM_W-1:0]       wt_wdata, wt_rdata;

   logic                    req_xfer, rsp_load;
   logic [CITY_W-1:0]       city_idx, last_city;
   logic [COUNT_W-1:0]      count_m1;
   logic [COORD_W-1:0]      rd_x, rd_y, cur_x, cur_y;
   logic [SQ_W:0]           sq_sum;
   logic [AMT_W:0]          dep_sum;
   logic [PH_AW-1:0]        dep_addr;
   logic [SUM_W-1:0]        cum_next;
   logic                    p1_skip;

   acs_ram #(.WIDTH(PHER_W), .DEPTH(PH_DEPTH)) u_pher_ram (
      .clock(clock), .wr_en(ph_we), .wr_addr(ph_waddr), .wr_data(ph_wdata),
      .rd_addr(ph_raddr), .rd_data(ph_rdata)
   );

   acs_ram #(.WIDTH(XY_W), .DEPTH(MAX_CITIES)) u_coord_ram (
      .clock(clock), .wr_en(co_we), .wr_addr(co_waddr), .wr_data(co_wdata),
      .rd_addr(co_raddr), .rd_data(co_rdata)
   );

   // Per-city {distance, weight} from the weighing pass, reread by the pick walk
   acs_ram #(.WIDTH(WRAM_W), .DEPTH(MAX_CITIES)) u_weight_ram (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(wt_wdata),
      .rd_addr(wt_raddr), .rd_data(wt_rdata)
   );

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.chosen_city   = rsp_data_ff.city;
   assign rsp_chan.step_distance = rsp_data_ff.distance;
   assign rsp_chan.none_left     = rsp_data_ff.none;

   // City index walked by both select passes
   assign city_idx = cnt_ff[CITY_W-1:0];

   // Clamp city_count to 1..MAX_CITIES, as a last index
   assign count_m1 = city_count_ff - COUNT_W'(1);
   always_comb begin
      if (city_count_ff == '0) begin
         last_city = '0;
      end else if (city_count_ff > COUNT_W'(MAX_CITIES)) begin
         last_city = CITY_W'(MAX_CITIES - 1);
      end else begin
         last_city = count_m1[CITY_W-1:0];
      end
   end

   assign rd_x  = co_rdata[COORD_W-1:0];
   assign rd_y  = co_rdata[XY_W-1:COORD_W];
   assign cur_x = cur_xy_ff[COORD_W-1:0];
   assign cur_y = cur_xy_ff[XY_W-1:COORD_W];

   // Divider step
   assign div_rsh      = {drem_ff, quo_ff[QUO_W-1]};
   assign div_sub      = div_rsh - {1'b0, dvs_ff};
   assign div_ge       = (div_rsh >= {1'b0, dvs_ff});
   assign div_rem_next = div_ge ? div_sub[DVS_W-1:0] : div_rsh[DVS_W-1:0];
   assign div_quo_next = {quo_ff[QUO_W-2:0], div_ge};

   // Threshold fold step
   assign fold_hi  = {{(SUM_W - QUO_W + FRAC_W){1'b0}}, quo_ff[QUO_W-1:FRAC_W]};
   assign fold_sum = {{FRAC_W{1'b0}}, quo_ff[QUO_W-1:FRAC_W]} +
                     {{(QUO_W - FRAC_W){1'b0}}, quo_ff[FRAC_W-1:0]};

   // Root step: bring down two radicand bits, try 4r+1
   assign sq_rt        = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign sq_trial     = {1'b0, root_ff, 2'b01};
   assign sq_diff      = sq_rt - sq_trial;
   assign sq_ge        = (sq_rt >= sq_trial);
   assign sq_rem_next  = sq_ge ? sq_diff[SREM_W-1:0] : sq_rt[SREM_W-1:0];
   assign sq_root_next = {root_ff[DIST_W-2:0], sq_ge};

   assign sq_sum   = {1'b0, acc_ff} + {1'b0, mul_ff[SQ_W-1:0]};
   assign dep_sum  = {{(AMT_W + 1 - PHER_W){1'b0}}, ph_rdata} + {1'b0, amt_ff};
   assign dep_addr = dep_pass_ff ? {b_ff, a_ff} : {a_ff, b_ff};
   assign cum_next = cum_ff + {{(SUM_W - WT_W){1'b0}}, wt_rdata[WT_W-1:0]};
   assign p1_skip  = visited_ff[city_idx] || (co_rdata == cur_xy_ff);

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_EVAP_MUL: begin
            mul_a = {{(MUL_AW - PHER_W){1'b0}}, ph_rdata};
            mul_b = evap_factor_ff;
         end
         ST_P1_MULX: begin
            mul_a = {{(MUL_AW - COORD_W){1'b0}}, dx_ff};
            mul_b = {{(MUL_BW - COORD_W){1'b0}}, dx_ff};
         end
         ST_P1_MULY: begin
            mul_a = {{(MUL_AW - COORD_W){1'b0}}, dy_ff};
            mul_b = {{(MUL_BW - COORD_W){1'b0}}, dy_ff};
         end
         ST_THR_MUL: begin
            mul_a = total_ff;
            mul_b = rnd_ff;
         end
         default: begin
         end
      endcase
   end
   assign mul_prod = {{(MUL_W - MUL_AW){1'b0}}, mul_a} * {{(MUL_W - MUL_BW){1'b0}}, mul_b};

   // RAM read address select
   always_comb begin
      ph_raddr = cnt_ff;
      co_raddr = city_idx;
      wt_raddr = city_idx;
      case (state_ff)
         ST_DEP_RD:  ph_raddr = dep_addr;
         ST_P1_RD:   ph_raddr = {cur_ff, city_idx};
         ST_SEL_CUR: co_raddr = cur_ff;
         default: begin
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      step_in        = step_ff;
      dep_pass_in    = dep_pass_ff;
      visited_in     = visited_ff;
      cur_in         = cur_ff;
      evap_factor_in = evap_factor_ff;
      deposit_qty_in = deposit_qty_ff;
      city_count_in  = city_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      rnd_in         = rnd_ff;
      cur_xy_in      = cur_xy_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      tau_in         = tau_ff;
      acc_in         = acc_ff;
      rad_in         = rad_ff;
      root_in        = root_ff;
      srem_in        = srem_ff;
      quo_in         = quo_ff;
      drem_in        = drem_ff;
      dvs_in         = dvs_ff;
      amt_in         = amt_ff;
      total_in       = total_ff;
      cum_in         = cum_ff;
      thr_in         = thr_ff;
      res_in         = res_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_load       = 1'b0;
      ph_we          = 1'b0;
      ph_waddr       = cnt_ff;
      ph_wdata       = PHER_ONE;
      co_we          = 1'b0;
      co_waddr       = req_chan.first_index;
      co_wdata       = {req_chan.coord_y, req_chan.coord_x};
      wt_we          = 1'b0;
      wt_waddr       = city_idx;
      wt_wdata       = '0;

      // Register writes land in any state
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_EVAP_FACTOR: evap_factor_in = csr_write_data;
            CSR_DEPOSIT_QTY: deposit_qty_in = csr_write_data;
            CSR_CITY_COUNT:  city_count_in  = csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end

      // Drop the response once transferred
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ph_we    = 1'b1;
            ph_waddr = cnt_ff;
            ph_wdata = PHER_ONE;
            cnt_in   = cnt_ff + PH_AW'(1);
            if (cnt_ff == PH_AW'(PH_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_xfer) begin
               a_in   = req_chan.first_index;
               b_in   = req_chan.second_index;
               rnd_in = req_chan.random_fraction;
               case (mode_type'(req_chan.mode))
                  MODE_LOAD: begin
                     co_we = 1'b1;
                  end
                  MODE_WRITE: begin
                     ph_we    = 1'b1;
                     ph_waddr = {req_chan.first_index, req_chan.second_index};
                     ph_wdata = req_chan.pheromone_word;
                  end
                  MODE_EVAP: begin
                     cnt_in   = '0;
                     state_in = ST_EVAP_RD;
                  end
                  MODE_DEPOSIT: begin
                     if (req_chan.tour_length != '0) begin
                        quo_in   = {{(QUO_W - CSR_DATA_W - 20){1'b0}}, deposit_qty_ff, 20'd0};
                        drem_in  = '0;
                        dvs_in   = req_chan.tour_length;
                        step_in  = '0;
                        state_in = ST_DEP_DIV;
                     end
                  end
                  MODE_START: begin
                     if (req_chan.first_index <= last_city) begin
                        visited_in = MAX_CITIES'(1) << req_chan.first_index;
                        cur_in     = req_chan.first_index;
                     end
                  end
                  MODE_SELECT: begin
                     state_in = ST_SEL_CUR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EVAP_RD: state_in = ST_EVAP_MUL;
         ST_EVAP_MUL: state_in = ST_EVAP_WR;
         ST_EVAP_WR: begin
            ph_we    = 1'b1;
            ph_waddr = cnt_ff;
            ph_wdata = mul_ff[PHER_W+15:16];
            cnt_in   = cnt_ff + PH_AW'(1);
            state_in = (cnt_ff == PH_AW'(PH_DEPTH - 1)) ? ST_IDLE : ST_EVAP_RD;
         end

         ST_DEP_DIV: begin
            quo_in  = div_quo_next;
            drem_in = div_rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               amt_in      = div_quo_next[AMT_W-1:0];
               dep_pass_in = 1'b0;
               state_in    = ST_DEP_RD;
            end
         end
         ST_DEP_RD: state_in = ST_DEP_WR;
         ST_DEP_WR: begin
            // Saturating add, forward edge then reverse edge
            ph_we    = 1'b1;
            ph_waddr = dep_addr;
            ph_wdata = (dep_sum[AMT_W:PHER_W] != '0) ? PHER_MAX : dep_sum[PHER_W-1:0];
            if (dep_pass_ff) begin
               state_in = ST_IDLE;
            end else begin
               dep_pass_in = 1'b1;
               state_in    = ST_DEP_RD;
            end
         end

         ST_SEL_CUR: state_in = ST_SEL_CURW;
         ST_SEL_CURW: begin
            cur_xy_in = co_rdata;
            cnt_in    = '0;
            total_in  = '0;
            state_in  = ST_P1_RD;
         end

         ST_P1_RD: state_in = ST_P1_CHK;
         ST_P1_CHK: begin
            dx_in  = (rd_x > cur_x) ? rd_x - cur_x : cur_x - rd_x;
            dy_in  = (rd_y > cur_y) ? rd_y - cur_y : cur_y - rd_y;
            tau_in = ph_rdata;
            if (p1_skip) begin
               // Visited or same place as current: weight and distance zero
               wt_we    = 1'b1;
               wt_wdata = '0;
               cnt_in   = cnt_ff + PH_AW'(1);
               state_in = (city_idx == last_city) ? ST_THR_MUL : ST_P1_RD;
            end else begin
               state_in = ST_P1_MULX;
            end
         end
         ST_P1_MULX: state_in = ST_P1_MULY;
         ST_P1_MULY: begin
            acc_in   = mul_ff[SQ_W-1:0];
            state_in = ST_P1_SUM;
         end
         ST_P1_SUM: begin
            rad_in   = {1'b0, sq_sum, 8'd0};
            root_in  = '0;
            srem_in  = '0;
            step_in  = '0;
            state_in = ST_P1_SQRT;
         end
         ST_P1_SQRT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            srem_in = sq_rem_next;
            root_in = sq_root_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               quo_in   = {{(QUO_W - PHER_W - 16){1'b0}}, tau_ff, 16'd0};
               drem_in  = '0;
               dvs_in   = {{(DVS_W - DIST_W){1'b0}}, sq_root_next};
               step_in  = '0;
               state_in = ST_P1_DIV;
            end
         end
         ST_P1_DIV: begin
            quo_in  = div_quo_next;
            drem_in = div_rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               wt_we    = 1'b1;
               wt_wdata = {root_ff, div_quo_next[WT_W-1:0]};
               total_in = total_ff + {{(SUM_W - WT_W){1'b0}}, div_quo_next[WT_W-1:0]};
               cnt_in   = cnt_ff + PH_AW'(1);
               state_in = (city_idx == last_city) ? ST_THR_MUL : ST_P1_RD;
            end
         end

         ST_THR_MUL: state_in = ST_THR_LD;
         ST_THR_LD: begin
            quo_in   = mul_ff[QUO_W-1:0];
            thr_in   = '0;
            state_in = ST_THR_DIV;
         end
         ST_THR_DIV: begin
            // Fold the high part down until the value fits 16 bits, then one compare
            if (quo_ff[QUO_W-1:FRAC_W] != '0) begin
               thr_in = thr_ff + fold_hi;
               quo_in = fold_sum;
            end else begin
               if (quo_ff[FRAC_W-1:0] == FRAC_DIV) begin
                  thr_in = thr_ff + SUM_W'(1);
               end
               cnt_in   = '0;
               cum_in   = '0;
               state_in = ST_P2_RD;
            end
         end

         ST_P2_RD: state_in = ST_P2_CHK;
         ST_P2_CHK: begin
            if (!visited_ff[city_idx] && (cum_next >= thr_ff)) begin
               res_in.city           = city_idx;
               res_in.distance       = wt_rdata[WRAM_W-1:WT_W];
               res_in.none           = 1'b0;
               visited_in[city_idx]  = 1'b1;
               cur_in                = city_idx;
               state_in              = ST_OUT;
            end else begin
               if (!visited_ff[city_idx]) begin
                  cum_in = cum_next;
               end
               if (city_idx == last_city) begin
                  res_in.city     = '0;
                  res_in.distance = '0;
                  res_in.none     = 1'b1;
                  state_in        = ST_OUT;
               end else begin
                  cnt_in   = cnt_ff + PH_AW'(1);
                  state_in = ST_P2_RD;
               end
            end
         end

         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cnt_ff         <= '0;
         visited_ff     <= '0;
         cur_ff         <= '0;
         evap_factor_ff <= 16'd32768;
         deposit_qty_ff <= 16'd100;
         city_count_ff  <= 7'd52;
         rsp_valid_ff   <= 1'b0;
         dep_pass_ff    <= 1'b0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         visited_ff     <= visited_in;
         cur_ff         <= cur_in;
         evap_factor_ff <= evap_factor_in;
         deposit_qty_ff <= deposit_qty_in;
         city_count_ff  <= city_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         dep_pass_ff    <= dep_pass_in;
         step_ff        <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      rnd_ff      <= rnd_in;
      cur_xy_ff   <= cur_xy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      tau_ff      <= tau_in;
      mul_ff      <= mul_prod;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      quo_ff      <= quo_in;
      drem_ff     <= drem_in;
      dvs_ff      <= dvs_in;
      amt_ff      <= amt_in;
      total_ff    <= total_in;
      cum_ff      <= cum_in;
      thr_ff      <= thr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A picked city is marked visited and becomes current
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && !res_ff.none |=> visited_ff[rsp_chan.chosen_city] &&
                                   (cur_ff == rsp_chan.chosen_city))
      else $error("picked city not recorded in tour state");

   // An empty pick carries no city and no distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.none_left |->
         (rsp_chan.chosen_city == '0) && (rsp_chan.step_distance == '0))
      else $error("none_left response with payload");

   // Divider partial remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEP_DIV || state_ff == ST_P1_DIV) |-> (drem_ff < dvs_ff))
      else $error("divider remainder out of range");

endmodule
`default_nettype wire

// File: sv/acs_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module acs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
